FILE: design/amc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amc_pkg: shared types and constants for the adjacency matrix connectivity block
// Item types, operation codes, microcode control word layout and the
// microcode program itself.
// ----------------------------------------------------------------------------
package amc_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;
  localparam logic [1:0] OP_COMPL  = 2'd3;

  // Width of a vertex field.
  localparam int VTX_W = 6;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic edge_present;
    logic connected;
    logic bad_vertex;
  } out_item_t;

  // Microcode step counter width.
  localparam int STEP_W = 4;

  // Jump conditions.
  localparam logic [2:0] COND_NONE     = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NO_INPUT = 3'd2;
  localparam logic [2:0] COND_BAD      = 3'd3;
  localparam logic [2:0] COND_COMPL    = 3'd4;
  localparam logic [2:0] COND_CNT_MORE = 3'd5;
  localparam logic [2:0] COND_CHANGED  = 3'd6;
  localparam logic [2:0] COND_OUT_FULL = 3'd7;

  // Read address selection.
  localparam logic [1:0] SEL_A   = 2'd0;
  localparam logic [1:0] SEL_B   = 2'd1;
  localparam logic [1:0] SEL_CNT = 2'd2;

  // Write kinds: which row is written and how it is formed.
  localparam logic [1:0] WR_EDGE_A = 2'd0;
  localparam logic [1:0] WR_EDGE_B = 2'd1;
  localparam logic [1:0] WR_COMPL  = 2'd2;

  // Program step addresses.
  localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
  localparam logic [STEP_W-1:0] ST_CHECK     = 4'd1;
  localparam logic [STEP_W-1:0] ST_READ_A    = 4'd2;
  localparam logic [STEP_W-1:0] ST_WRITE_A   = 4'd3;
  localparam logic [STEP_W-1:0] ST_WRITE_B   = 4'd4;
  localparam logic [STEP_W-1:0] ST_CMP_READ  = 4'd5;
  localparam logic [STEP_W-1:0] ST_CMP_WRITE = 4'd6;
  localparam logic [STEP_W-1:0] ST_SEEN_INIT = 4'd7;
  localparam logic [STEP_W-1:0] ST_PASS      = 4'd8;
  localparam logic [STEP_W-1:0] ST_WALK_RD   = 4'd9;
  localparam logic [STEP_W-1:0] ST_WALK_ACC  = 4'd10;
  localparam logic [STEP_W-1:0] ST_PASS_END  = 4'd11;
  localparam logic [STEP_W-1:0] ST_RESULT    = 4'd12;
  localparam logic [STEP_W-1:0] ST_RETURN    = 4'd13;

  // One control word of the microcode program.
  typedef struct packed {
    logic              in_rdy;
    logic [1:0]        rd_sel;
    logic              wr_en;
    logic [1:0]        wr_kind;
    logic              cnt_clr;
    logic              cnt_inc;
    logic              seen_init;
    logic              chg_clr;
    logic              accum;
    logic              edge_capture;
    logic              out_load;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Datapath flags that the jump conditions test.
  typedef struct packed {
    logic in_valid;
    logic bad;
    logic compl;
    logic cnt_more;
    logic changed;
    logic out_full;
  } status_t;

  // The microcode program.
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    w.rd_sel = SEL_CNT;
    unique case (step)
      ST_IDLE: begin
        // Wait for an item.
        w.in_rdy = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = ST_IDLE;
      end
      ST_CHECK: begin
        w.cnt_clr = 1'b1;
        w.cond    = COND_BAD;
        w.target  = ST_SEEN_INIT;
      end
      ST_READ_A: begin
        w.rd_sel = SEL_A;
        w.cond   = COND_COMPL;
        w.target = ST_CMP_READ;
      end
      ST_WRITE_A: begin
        w.rd_sel       = SEL_B;
        w.wr_en        = 1'b1;
        w.wr_kind      = WR_EDGE_A;
        w.edge_capture = 1'b1;
      end
      ST_WRITE_B: begin
        w.wr_en   = 1'b1;
        w.wr_kind = WR_EDGE_B;
        w.cond    = COND_ALWAYS;
        w.target  = ST_SEEN_INIT;
      end
      ST_CMP_READ: begin
        w.rd_sel = SEL_CNT;
      end
      ST_CMP_WRITE: begin
        w.wr_en   = 1'b1;
        w.wr_kind = WR_COMPL;
        w.cnt_inc = 1'b1;
        w.cond    = COND_CNT_MORE;
        w.target  = ST_CMP_READ;
      end
      ST_SEEN_INIT: begin
        w.seen_init = 1'b1;
      end
      ST_PASS: begin
        w.cnt_clr = 1'b1;
        w.chg_clr = 1'b1;
      end
      ST_WALK_RD: begin
        w.rd_sel = SEL_CNT;
      end
      ST_WALK_ACC: begin
        w.accum   = 1'b1;
        w.cnt_inc = 1'b1;
        w.cond    = COND_CNT_MORE;
        w.target  = ST_WALK_RD;
      end
      ST_PASS_END: begin
        w.cond   = COND_CHANGED;
        w.target = ST_PASS;
      end
      ST_RESULT: begin
        w.out_load = 1'b1;
        w.cond     = COND_OUT_FULL;
        w.target   = ST_RESULT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/amc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amc_seq: microcode sequencer
// Holds the step counter, fetches the control word from the program table
// and takes conditional jumps on the datapath flags.
// ----------------------------------------------------------------------------
module amc_seq (
  input  logic             clk,
  input  logic             rst,
  input  amc_pkg::status_t status,
  output amc_pkg::ctrl_t   ctrl
);

  logic [amc_pkg::STEP_W-1:0] step;
  logic [amc_pkg::STEP_W-1:0] step_next;
  logic                       take;

  // Fetch the control word of the current step.
  assign ctrl = amc_pkg::ucode_rom(step);

  // Evaluate the jump condition.
  always_comb begin
    unique case (ctrl.cond)
      amc_pkg::COND_NONE:     take = 1'b0;
      amc_pkg::COND_ALWAYS:   take = 1'b1;
      amc_pkg::COND_NO_INPUT: take = !status.in_valid;
      amc_pkg::COND_BAD:      take = status.bad;
      amc_pkg::COND_COMPL:    take = status.compl;
      amc_pkg::COND_CNT_MORE: take = status.cnt_more;
      amc_pkg::COND_CHANGED:  take = status.changed;
      amc_pkg::COND_OUT_FULL: take = status.out_full;
      default:                take = 1'b0;
    endcase
    step_next = take ? ctrl.target : step + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= amc_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: design/amc_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amc_matrix: adjacency row memory
// One row per vertex, one write and one registered read a cycle. A valid
// bit per row makes rows that were never written read as zero after reset.
// ----------------------------------------------------------------------------
module amc_matrix #(
  parameter int NUM_VERTICES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(NUM_VERTICES)-1:0] rd_addr,
  output logic [NUM_VERTICES-1:0]         rd_row,
  input  logic                            wr_en,
  input  logic [$clog2(NUM_VERTICES)-1:0] wr_addr,
  input  logic [NUM_VERTICES-1:0]         wr_row
);

  logic [NUM_VERTICES-1:0] mem [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] row_valid;
  logic [NUM_VERTICES-1:0] rd_data;
  logic                    rd_valid;

  // Row storage and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    rd_data <= mem[rd_addr];
  end

  // Valid bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid <= row_valid[rd_addr];
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

FILE: design/adjacency_matrix_connectivity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_connectivity: undirected graph edit and connectivity check
// Keeps an undirected adjacency bit matrix and reports, after each item,
// the edge bit and whether every vertex is reachable from vertex 0.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_item) takes one item with an
//   opcode (add, remove, test edge, complement matrix) and two endpoints.
//   The output channel (out_valid, out_ready, out_item) returns one result
//   item per input item, in order.
//   Order of work after an item is accepted: the edit comes first. An edge
//   item reads both endpoint rows and, for an add or remove, rewrites them;
//   a complement reads and inverts every row in turn, and an item with an
//   endpoint out of range skips the edit. The reachability walk then sweeps
//   over the rows again and again until the reached set stops growing, in
//   1 to N sweeps. The result is then loaded into the output register, and
//   the sequencer returns to idle before the next item is accepted.
//   The rows are read one at a time through the single read port of the
//   row memory, under the microcode program.
//   Reset clears the whole matrix at once through per-row valid bits, so
//   an item can be taken in the first cycle after reset.
//   One finished result is held in the output register; the next item is
//   accepted while it waits, and its own result waits in the sequencer
//   until the register is free.
// ----------------------------------------------------------------------------
module adjacency_matrix_connectivity #(
  parameter int NUM_VERTICES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  amc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output amc_pkg::out_item_t out_item
);

  localparam int IW = $clog2(NUM_VERTICES);

  amc_pkg::ctrl_t   ctrl;
  amc_pkg::status_t status;

  logic [1:0]              op;
  logic [IW-1:0]           va;
  logic [IW-1:0]           vb;
  logic                    bad;
  logic                    present;
  logic [NUM_VERTICES-1:0] seen;
  logic                    changed;
  logic [IW-1:0]           cnt;

  logic [IW-1:0]           rd_addr;
  logic [NUM_VERTICES-1:0] rd_row;
  logic                    wr_en;
  logic [IW-1:0]           wr_addr;
  logic [NUM_VERTICES-1:0] wr_row;
  logic [NUM_VERTICES-1:0] bit_a;
  logic [NUM_VERTICES-1:0] bit_b;
  logic [NUM_VERTICES-1:0] grown;
  logic                    in_bad;
  logic                    accept;
  logic                    out_full;

  amc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  amc_matrix #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_matrix (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row)
  );

  // Input handshake.
  assign in_ready = ctrl.in_rdy && !rst;
  assign accept   = in_valid && in_ready;
  assign in_bad   = (in_item.opcode != amc_pkg::OP_COMPL) &&
                    (({1'b0, in_item.vertex_a} >= (amc_pkg::VTX_W + 1)'(NUM_VERTICES)) ||
                     ({1'b0, in_item.vertex_b} >= (amc_pkg::VTX_W + 1)'(NUM_VERTICES)));
  assign out_full = out_valid && !out_ready;

  // Flags for the sequencer.
  assign status.in_valid = in_valid;
  assign status.bad      = bad;
  assign status.compl    = (op == amc_pkg::OP_COMPL);
  assign status.cnt_more = (cnt != IW'(NUM_VERTICES - 1));
  assign status.changed  = changed;
  assign status.out_full = out_full;

  // Row read address.
  always_comb begin
    case (ctrl.rd_sel)
      amc_pkg::SEL_A: rd_addr = va;
      amc_pkg::SEL_B: rd_addr = vb;
      default:        rd_addr = cnt;
    endcase
  end

  // Row write: set or clear one edge bit, or complement a whole row.
  assign bit_a = NUM_VERTICES'(1) << va;
  assign bit_b = NUM_VERTICES'(1) << vb;

  always_comb begin
    case (ctrl.wr_kind)
      amc_pkg::WR_EDGE_A: begin
        wr_addr = va;
        wr_row  = (op == amc_pkg::OP_ADD) ? (rd_row | bit_b) : (rd_row & ~bit_b);
        wr_en   = ctrl.wr_en && (op != amc_pkg::OP_TEST);
      end
      amc_pkg::WR_EDGE_B: begin
        wr_addr = vb;
        wr_row  = (op == amc_pkg::OP_ADD) ? (rd_row | bit_a) : (rd_row & ~bit_a);
        wr_en   = ctrl.wr_en && (op != amc_pkg::OP_TEST);
      end
      default: begin
        wr_addr = cnt;
        wr_row  = ~rd_row;
        wr_en   = ctrl.wr_en;
      end
    endcase
  end

  // Reached set widened by the row of a reached vertex.
  assign grown = seen[cnt] ? (seen | rd_row) : seen;

  // Item capture and walk registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= in_item.opcode;
      va      <= in_item.vertex_a[IW-1:0];
      vb      <= in_item.vertex_b[IW-1:0];
      bad     <= in_bad;
      present <= 1'b0;
    end
    if (ctrl.edge_capture) begin
      case (op)
        amc_pkg::OP_ADD:    present <= 1'b1;
        amc_pkg::OP_REMOVE: present <= 1'b0;
        default:            present <= rd_row[vb];
      endcase
    end
    if (ctrl.cnt_clr) begin
      cnt <= '0;
    end else if (ctrl.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
    if (ctrl.seen_init) begin
      seen <= NUM_VERTICES'(1);
    end else if (ctrl.accum) begin
      seen <= grown;
    end
    if (ctrl.chg_clr) begin
      changed <= 1'b0;
    end else if (ctrl.accum && (grown != seen)) begin
      changed <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load && !out_full) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && !out_full) begin
      out_item.edge_present <= present;
      out_item.connected    <= &seen;
      out_item.bad_vertex   <= bad;
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for adjacency_matrix_connectivity
// Edits a 16-vertex undirected graph through add, remove, test and
// complement items. A shadow copy of the adjacency matrix predicts the edge
// bit, the out-of-range flag and reachability from vertex 0 for every item.
// Each returned result is compared field by field against the prediction.
// Directed corner items run first, then random items in growing and
// shrinking bursts, under three patterns of idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NV = 16;
  localparam int VW = amc_pkg::VTX_W;
  localparam int RANDOM_PER_PHASE = 284;
  localparam int BURST_LEN = 40;
  localparam int DRAIN_CYCLES = 700;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  amc_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  amc_pkg::out_item_t out_item;

  int unsigned send_idle_pct;
  int unsigned take_idle_pct;

  // Shadow graph that predicts one result per accepted item.
  class graph_checker;
    logic [NV-1:0]      rows [NV];
    amc_pkg::out_item_t predicted_q [$];
    int unsigned        failures;

    function new();
      foreach (rows[i]) rows[i] = '0;
      failures = 0;
    endfunction

    // Grows the reached set from vertex 0 until it stops changing.
    function bit reaches_all();
      logic [NV-1:0] seen;
      logic [NV-1:0] grown;
      seen = NV'(1);
      for (int pass = 0; pass < NV; pass++) begin
        grown = seen;
        for (int v = 0; v < NV; v++) begin
          if (seen[v]) grown = grown | rows[v];
        end
        if (grown == seen) break;
        seen = grown;
      end
      return &seen;
    endfunction

    function void note_item(amc_pkg::in_item_t item);
      amc_pkg::out_item_t r;
      r = '0;
      if (item.opcode == amc_pkg::OP_COMPL) begin
        foreach (rows[i]) rows[i] = ~rows[i];
      end else if (item.vertex_a >= NV || item.vertex_b >= NV) begin
        r.bad_vertex = 1'b1;
      end else begin
        case (item.opcode)
          amc_pkg::OP_ADD: begin
            rows[item.vertex_a][item.vertex_b] = 1'b1;
            rows[item.vertex_b][item.vertex_a] = 1'b1;
          end
          amc_pkg::OP_REMOVE: begin
            rows[item.vertex_a][item.vertex_b] = 1'b0;
            rows[item.vertex_b][item.vertex_a] = 1'b0;
          end
          default: begin
          end
        endcase
        r.edge_present = rows[item.vertex_a][item.vertex_b];
      end
      r.connected = reaches_all();
      predicted_q.insert(predicted_q.size(), r);
    endfunction

    function void check_result(amc_pkg::out_item_t got);
      amc_pkg::out_item_t want;
      if (predicted_q.size() == 0) begin
        $error("result item arrived with no item outstanding");
        failures++;
        return;
      end
      want = predicted_q.pop_front();
      if (got.edge_present !== want.edge_present) begin
        $error("edge_present: expected %0b, actual %0b", want.edge_present, got.edge_present);
        failures++;
      end
      if (got.connected !== want.connected) begin
        $error("connected: expected %0b, actual %0b", want.connected, got.connected);
        failures++;
      end
      if (got.bad_vertex !== want.bad_vertex) begin
        $error("bad_vertex: expected %0b, actual %0b", want.bad_vertex, got.bad_vertex);
        failures++;
      end
    endfunction
  endclass

  graph_checker sb;

  adjacency_matrix_connectivity #(
    .NUM_VERTICES(NV)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Result side: random back-pressure set at the falling edge.
  always @(negedge clk) begin
    if (rst) out_ready = 1'b0;
    else out_ready = ($urandom_range(0, 99) >= take_idle_pct);
  end

  // Result side: every accepted result is checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
  end

  // Offers one item after a random gap and holds it until it is accepted.
  // Entered and left at a falling edge.
  task automatic send_item(amc_pkg::in_item_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = item;
    do @(posedge clk); while (!in_ready);
    sb.note_item(item);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] op, logic [VW-1:0] a, logic [VW-1:0] b);
    amc_pkg::in_item_t item;
    item.opcode   = op;
    item.vertex_a = a;
    item.vertex_b = b;
    send_item(item);
  endtask

  // Random item; a growing burst favors adds, a shrinking one removes.
  function automatic amc_pkg::in_item_t random_edit(bit growing);
    amc_pkg::in_item_t item;
    int unsigned roll;
    int unsigned pick;
    item.vertex_a = VW'($urandom_range(0, NV - 1));
    item.vertex_b = VW'($urandom_range(0, NV - 1));
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      // Complement; the endpoints carry noise that must be ignored.
      item.opcode   = amc_pkg::OP_COMPL;
      item.vertex_a = VW'($urandom());
      item.vertex_b = VW'($urandom());
    end else if (roll < 14) begin
      // One endpoint out of range, the other anything.
      item.opcode = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) begin
        item.vertex_a = VW'($urandom_range(NV, 63));
        item.vertex_b = VW'($urandom());
      end else begin
        item.vertex_a = VW'($urandom());
        item.vertex_b = VW'($urandom_range(NV, 63));
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 20) item.opcode = amc_pkg::OP_TEST;
      else if (pick < (growing ? 85 : 35)) item.opcode = amc_pkg::OP_ADD;
      else item.opcode = amc_pkg::OP_REMOVE;
    end
    return item;
  endfunction

  // Main stimulus.
  initial begin
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_item       = '0;
    out_ready     = 1'b0;
    send_idle_pct = 30;
    take_idle_pct = 77;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: empty graph, self loops, extreme vertices,
    // out-of-range endpoints for every edge operation, and complement.
    send_fields(amc_pkg::OP_TEST, 6'd0, 6'd0);
    send_fields(amc_pkg::OP_ADD, 6'd0, 6'd0);
    send_fields(amc_pkg::OP_TEST, 6'd0, 6'd0);
    send_fields(amc_pkg::OP_ADD, 6'd0, 6'd15);
    send_fields(amc_pkg::OP_TEST, 6'd15, 6'd0);
    send_fields(amc_pkg::OP_REMOVE, 6'd15, 6'd0);
    send_fields(amc_pkg::OP_ADD, 6'd63, 6'd63);
    send_fields(amc_pkg::OP_REMOVE, 6'd5, 6'd40);
    send_fields(amc_pkg::OP_TEST, 6'd16, 6'd1);
    send_fields(amc_pkg::OP_ADD, 6'd1, 6'd16);
    send_fields(amc_pkg::OP_COMPL, 6'd63, 6'd42);
    send_fields(amc_pkg::OP_TEST, 6'd3, 6'd3);
    send_fields(amc_pkg::OP_REMOVE, 6'd0, 6'd0);
    send_fields(amc_pkg::OP_REMOVE, 6'd15, 6'd15);
    send_fields(amc_pkg::OP_TEST, 6'd63, 6'd0);
    send_fields(amc_pkg::OP_REMOVE, 6'd0, 6'd1);
    send_fields(amc_pkg::OP_TEST, 6'd1, 6'd0);
    send_fields(amc_pkg::OP_COMPL, 6'd0, 6'd0);
    send_fields(amc_pkg::OP_TEST, 6'd0, 6'd1);
    send_fields(amc_pkg::OP_ADD, 6'd14, 6'd15);
    send_fields(amc_pkg::OP_COMPL, 6'd21, 6'd0);

    // Random bursts under three idling patterns.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 30;
          take_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          take_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        send_item(random_edit(((k / BURST_LEN) % 2) == 0));
      end
    end
    in_valid = 1'b0;

    // Drain outstanding results, then watch for strays.
    while (sb.predicted_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
